@@ hdl/twtl_pkg.sv @@
// Package for the two-way traffic light controller.
// Holds modes, lamp codes, payload structs, register indexes and the segment table.
// No dependencies.
`timescale 1ns / 1ps

package twtl_pkg;

  typedef enum logic [2:0] {
    MODE_DARK     = 3'd0,
    MODE_CYCLE    = 3'd1,
    MODE_BLINK    = 3'd2,
    MODE_PRIO_ONE = 3'd3,
    MODE_PRIO_TWO = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    LAMP_OFF    = 2'd0,
    LAMP_GREEN  = 2'd1,
    LAMP_YELLOW = 2'd2,
    LAMP_RED    = 2'd3
  } lamp_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_GREEN_ONE  = 2'd0;
  localparam logic [1:0] CFG_YELLOW_ONE = 2'd1;
  localparam logic [1:0] CFG_GREEN_TWO  = 2'd2;
  localparam logic [1:0] CFG_YELLOW_TWO = 2'd3;

  localparam logic [6:0] GREEN_RESET  = 7'd10;
  localparam logic [4:0] YELLOW_RESET = 5'd3;
  localparam logic [6:0] COUNT_MAX    = 7'd99;
  localparam logic [7:0] SEG_BLANK    = 8'hFF;
  localparam logic [7:0] PHASE_MAX    = 8'hFF;

  typedef struct packed {
    logic press_auto;
    logic press_off;
    logic press_flash;
    logic press_prio_one;
    logic press_prio_two;
    logic second_tick;
  } in_item_t;

  typedef struct packed {
    lamp_t      lamp_one;
    lamp_t      lamp_two;
    logic [7:0] seg_one_units;
    logic [7:0] seg_one_tens;
    logic [7:0] seg_two_units;
    logic [7:0] seg_two_tens;
  } out_item_t;

  // Common-anode, active-low digit codes
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hc0;
      4'd1:    code = 8'hf9;
      4'd2:    code = 8'ha4;
      4'd3:    code = 8'hb0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hf8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  function automatic logic [6:0] clamp99(input logic [8:0] v);
    return (v > {2'b00, COUNT_MAX}) ? COUNT_MAX : v[6:0];
  endfunction

endpackage

@@ hdl/twtl_in_if.sv @@
// Input channel of the traffic light controller: buttons and second tick.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface twtl_in_if;
  logic valid;
  logic ready;
  logic press_auto;
  logic press_off;
  logic press_flash;
  logic press_prio_one;
  logic press_prio_two;
  logic second_tick;

  modport source (
    output valid, press_auto, press_off, press_flash, press_prio_one, press_prio_two,
           second_tick,
    input  ready
  );
  modport sink (
    input  valid, press_auto, press_off, press_flash, press_prio_one, press_prio_two,
           second_tick,
    output ready
  );
endinterface

@@ hdl/twtl_out_if.sv @@
// Output channel of the traffic light controller: lamp heads and segment bytes.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface twtl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lamp_one;
  logic [1:0] lamp_two;
  logic [7:0] seg_one_units;
  logic [7:0] seg_one_tens;
  logic [7:0] seg_two_units;
  logic [7:0] seg_two_tens;

  modport source (
    output valid, lamp_one, lamp_two, seg_one_units, seg_one_tens, seg_two_units,
           seg_two_tens,
    input  ready
  );
  modport sink (
    input  valid, lamp_one, lamp_two, seg_one_units, seg_one_tens, seg_two_units,
           seg_two_tens,
    output ready
  );
endinterface

@@ hdl/twtl_core.sv @@
// Control pass of the traffic light controller: timing registers, mode,
// phase counter and countdowns, lamp decode and digit encode. Uses twtl_pkg.
`timescale 1ns / 1ps

module twtl_core import twtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       step,
  input  in_item_t   item,
  output out_item_t  result
);

  logic [6:0] green_one;
  logic [4:0] yellow_one;
  logic [6:0] green_two;
  logic [4:0] yellow_two;

  mode_t      mode, mode_next;
  logic [7:0] phase, phase_next;
  logic [6:0] count_one, count_one_next;
  logic [6:0] count_two, count_two_next;

  logic [8:0] b1, b2, b3, total;
  logic [8:0] ph_ext;
  lamp_t      lamp_one, lamp_two;
  logic       show;

  logic [6:0]  c1, c2;
  logic [14:0] prod1, prod2;
  logic [3:0]  tens1, tens2;
  logic [6:0]  units1, units2;

  always_ff @(posedge clk) begin
    if (rst) begin
      green_one  <= GREEN_RESET;
      yellow_one <= YELLOW_RESET;
      green_two  <= GREEN_RESET;
      yellow_two <= YELLOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GREEN_ONE:  green_one  <= cfg_data;
        CFG_YELLOW_ONE: yellow_one <= cfg_data[4:0];
        CFG_GREEN_TWO:  green_two  <= cfg_data;
        CFG_YELLOW_TWO: yellow_two <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_DARK;
      phase     <= '0;
      count_one <= '0;
      count_two <= '0;
    end else if (step) begin
      mode      <= mode_next;
      phase     <= phase_next;
      count_one <= count_one_next;
      count_two <= count_two_next;
    end
  end

  assign b1    = {2'b00, green_one};
  assign b2    = b1 + {4'b0000, yellow_one};
  assign b3    = b2 + {2'b00, green_two};
  assign total = b3 + {4'b0000, yellow_two};

  always_comb begin
    // later button wins
    mode_next = mode;
    if (item.press_auto)     mode_next = MODE_CYCLE;
    if (item.press_off)      mode_next = MODE_DARK;
    if (item.press_flash)    mode_next = MODE_BLINK;
    if (item.press_prio_one) mode_next = MODE_PRIO_ONE;
    if (item.press_prio_two) mode_next = MODE_PRIO_TWO;

    phase_next     = phase;
    count_one_next = count_one;
    count_two_next = count_two;
    lamp_one       = LAMP_OFF;
    lamp_two       = LAMP_OFF;
    show           = 1'b0;
    ph_ext         = '0;

    case (mode_next)
      MODE_CYCLE: begin
        if (item.second_tick) begin
          if (phase != PHASE_MAX) phase_next = phase + 8'd1;
          if (count_one != '0) count_one_next = count_one - 7'd1;
          if (count_two != '0) count_two_next = count_two - 7'd1;
        end
        if ({1'b0, phase_next} >= total) phase_next = '0;
        ph_ext = {1'b0, phase_next};

        if (ph_ext < b1) begin
          lamp_one = LAMP_GREEN;  lamp_two = LAMP_RED;
        end else if (ph_ext < b2) begin
          lamp_one = LAMP_YELLOW; lamp_two = LAMP_RED;
        end else if (ph_ext < b3) begin
          lamp_one = LAMP_RED;    lamp_two = LAMP_GREEN;
        end else if (ph_ext < total) begin
          lamp_one = LAMP_RED;    lamp_two = LAMP_YELLOW;
        end

        // reload at phase boundaries; a later match overrides
        if (ph_ext == '0) begin
          count_one_next = clamp99(b1);
          count_two_next = clamp99(b2);
        end
        if (ph_ext == b1) begin
          count_one_next = clamp99({4'b0000, yellow_one});
          count_two_next = clamp99({4'b0000, yellow_one});
        end
        if (ph_ext == b2) begin
          count_one_next = clamp99({2'b00, green_two} + {4'b0000, yellow_two});
          count_two_next = clamp99({2'b00, green_two});
        end
        if (ph_ext == b3) begin
          count_one_next = clamp99({4'b0000, yellow_two});
          count_two_next = clamp99({4'b0000, yellow_two});
        end
        show = 1'b1;
      end
      MODE_BLINK: begin
        if (item.second_tick && phase != PHASE_MAX) phase_next = phase + 8'd1;
        if (phase_next >= 8'd2) phase_next = '0;
        if (phase_next == '0) begin
          lamp_one = LAMP_YELLOW; lamp_two = LAMP_YELLOW;
        end
      end
      MODE_PRIO_ONE: begin
        lamp_one = LAMP_YELLOW; lamp_two = LAMP_RED;
      end
      MODE_PRIO_TWO: begin
        lamp_one = LAMP_RED;    lamp_two = LAMP_YELLOW;
      end
      default: mode_next = MODE_DARK;
    endcase
  end

  // split into digits: divide by ten through multiply by 205, shift by 11
  assign c1     = clamp99({2'b00, count_one_next});
  assign c2     = clamp99({2'b00, count_two_next});
  assign prod1  = {8'd0, c1} * 15'd205;
  assign prod2  = {8'd0, c2} * 15'd205;
  assign tens1  = prod1[14:11];
  assign tens2  = prod2[14:11];
  assign units1 = c1 - (({3'b000, tens1} << 3) + ({3'b000, tens1} << 1));
  assign units2 = c2 - (({3'b000, tens2} << 3) + ({3'b000, tens2} << 1));

  always_comb begin
    result.lamp_one = lamp_one;
    result.lamp_two = lamp_two;
    if (show) begin
      result.seg_one_units = seg_code(units1[3:0]);
      result.seg_one_tens  = seg_code(tens1);
      result.seg_two_units = seg_code(units2[3:0]);
      result.seg_two_tens  = seg_code(tens2);
    end else begin
      result.seg_one_units = SEG_BLANK;
      result.seg_one_tens  = SEG_BLANK;
      result.seg_two_units = SEG_BLANK;
      result.seg_two_tens  = SEG_BLANK;
    end
  end

endmodule

@@ hdl/two_way_traffic_light_controller.sv @@
// Two-way traffic light controller, top level. An input transfer goes into the input
// register, then through the control pass into the result register. Throughput: one
// control pass per cycle while the result register is not held by the receiver.
// Reset (synchronous, active high) selects off mode, clears phase and countdowns,
// loads the default times (green 10 s, yellow 3 s) and empties both registers.
// Uses twtl_pkg, twtl_in_if, twtl_out_if and twtl_core.
`timescale 1ns / 1ps

module two_way_traffic_light_controller import twtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  twtl_in_if.sink    pass_in,
  twtl_out_if.source lamps_out,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  in_item_t  in_reg;
  logic      in_valid;
  out_item_t out_reg;
  logic      out_valid;
  out_item_t result;
  logic      advance;
  logic      take;

  // advance the held pass whenever the result register is free or being drained
  assign advance       = in_valid && (!out_valid || lamps_out.ready);
  assign pass_in.ready = !in_valid || advance;
  assign take          = pass_in.valid && pass_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pass_in.ready) begin
      in_valid <= pass_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_reg.press_auto     <= pass_in.press_auto;
      in_reg.press_off      <= pass_in.press_off;
      in_reg.press_flash    <= pass_in.press_flash;
      in_reg.press_prio_one <= pass_in.press_prio_one;
      in_reg.press_prio_two <= pass_in.press_prio_two;
      in_reg.second_tick    <= pass_in.second_tick;
    end
  end

  twtl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (in_reg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (lamps_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign lamps_out.valid         = out_valid;
  assign lamps_out.lamp_one      = out_reg.lamp_one;
  assign lamps_out.lamp_two      = out_reg.lamp_two;
  assign lamps_out.seg_one_units = out_reg.seg_one_units;
  assign lamps_out.seg_one_tens  = out_reg.seg_one_tens;
  assign lamps_out.seg_two_units = out_reg.seg_two_units;
  assign lamps_out.seg_two_tens  = out_reg.seg_two_tens;

  a_advance_fills : assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not filled after a control pass");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !pass_in.ready |-> (in_valid && out_valid && !lamps_out.ready))
    else $error("input stalled without a blocked result");

  a_no_double_green : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_reg.lamp_one == LAMP_GREEN && out_reg.lamp_two == LAMP_GREEN))
    else $error("both roads green");

  a_blank_together : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_reg.seg_one_units == SEG_BLANK) ==
                   (out_reg.seg_two_tens == SEG_BLANK)))
    else $error("digits blanked only in part");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!out_valid && !in_valid))
    else $error("pipeline not empty after reset");

endmodule

@@ bench/tb_two_way_traffic_light_controller.sv @@
// Testbench for the two-way traffic light controller: directed and random control passes,
// with the lamps and segment bytes predicted per pass and checked in order.
// Depends on twtl_pkg, twtl_in_if, twtl_out_if and two_way_traffic_light_controller.
`timescale 1ns / 1ps

module tb_two_way_traffic_light_controller;
  import twtl_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  // Predicts each control pass and holds the lamp and digit results still due.
  class lamp_ledger;
    mode_t      mode;
    bit [7:0]   phase;
    bit [6:0]   count_one;
    bit [6:0]   count_two;
    bit [6:0]   green_one;
    bit [4:0]   yellow_one;
    bit [6:0]   green_two;
    bit [4:0]   yellow_two;
    out_item_t  due_lamps[$];
    int         errors;
    bit [7:0]   digit_glyph [10] = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99,
                                     8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};

    function new();
      mode       = MODE_DARK;
      phase      = '0;
      count_one  = '0;
      count_two  = '0;
      green_one  = GREEN_RESET;
      yellow_one = YELLOW_RESET;
      green_two  = GREEN_RESET;
      yellow_two = YELLOW_RESET;
      errors     = 0;
    endfunction

    function void set_timing(logic [1:0] idx, logic [6:0] val);
      case (idx)
        CFG_GREEN_ONE:  green_one  = val;
        CFG_YELLOW_ONE: yellow_one = val[4:0];
        CFG_GREEN_TWO:  green_two  = val;
        CFG_YELLOW_TWO: yellow_two = val[4:0];
        default: ;
      endcase
    endfunction

    function bit [6:0] cap_count(int v);
      return (v > 99) ? 7'd99 : v[6:0];
    endfunction

    function out_item_t run_control_pass(in_item_t p);
      out_item_t r;
      int b1, b2, b3, total;
      bit show;
      r.lamp_one = LAMP_OFF;
      r.lamp_two = LAMP_OFF;
      show = 1'b0;
      // later button wins
      if (p.press_auto)     mode = MODE_CYCLE;
      if (p.press_off)      mode = MODE_DARK;
      if (p.press_flash)    mode = MODE_BLINK;
      if (p.press_prio_one) mode = MODE_PRIO_ONE;
      if (p.press_prio_two) mode = MODE_PRIO_TWO;
      case (mode)
        MODE_CYCLE: begin
          b1 = green_one;
          b2 = b1 + yellow_one;
          b3 = b2 + green_two;
          total = b3 + yellow_two;
          if (p.second_tick) begin
            if (phase != 8'hFF) phase++;
            if (count_one != 0) count_one--;
            if (count_two != 0) count_two--;
          end
          if (phase >= total) phase = '0;
          if (phase < b1) begin
            r.lamp_one = LAMP_GREEN;  r.lamp_two = LAMP_RED;
          end else if (phase < b2) begin
            r.lamp_one = LAMP_YELLOW; r.lamp_two = LAMP_RED;
          end else if (phase < b3) begin
            r.lamp_one = LAMP_RED;    r.lamp_two = LAMP_GREEN;
          end else if (phase < total) begin
            r.lamp_one = LAMP_RED;    r.lamp_two = LAMP_YELLOW;
          end
          // later boundary match overrides an earlier one
          if (phase == 0) begin
            count_one = cap_count(b1);
            count_two = cap_count(b2);
          end
          if (phase == b1) begin
            count_one = cap_count(yellow_one);
            count_two = cap_count(yellow_one);
          end
          if (phase == b2) begin
            count_one = cap_count(int'(green_two) + int'(yellow_two));
            count_two = cap_count(green_two);
          end
          if (phase == b3) begin
            count_one = cap_count(yellow_two);
            count_two = cap_count(yellow_two);
          end
          show = 1'b1;
        end
        MODE_BLINK: begin
          if (p.second_tick && phase != 8'hFF) phase++;
          if (phase >= 2) phase = '0;
          if (phase == 0) begin
            r.lamp_one = LAMP_YELLOW; r.lamp_two = LAMP_YELLOW;
          end
        end
        MODE_PRIO_ONE: begin
          r.lamp_one = LAMP_YELLOW; r.lamp_two = LAMP_RED;
        end
        MODE_PRIO_TWO: begin
          r.lamp_one = LAMP_RED;    r.lamp_two = LAMP_YELLOW;
        end
        default: mode = MODE_DARK;
      endcase
      if (show) begin
        r.seg_one_units = digit_glyph[count_one % 10];
        r.seg_one_tens  = digit_glyph[count_one / 10];
        r.seg_two_units = digit_glyph[count_two % 10];
        r.seg_two_tens  = digit_glyph[count_two / 10];
      end else begin
        r.seg_one_units = SEG_BLANK;
        r.seg_one_tens  = SEG_BLANK;
        r.seg_two_units = SEG_BLANK;
        r.seg_two_tens  = SEG_BLANK;
      end
      return r;
    endfunction

    function void note_pass(in_item_t p);
      due_lamps.push_back(run_control_pass(p));
    endfunction

    function int pending();
      return due_lamps.size();
    endfunction

    task report(string what);
      errors++;
      $display("%0t: mismatch: %s", $realtime, what);
    endtask

    task check_lamps(out_item_t got);
      out_item_t want;
      if (due_lamps.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      want = due_lamps.pop_front();
      if (got.lamp_one !== want.lamp_one)
        report($sformatf("lamp_one got %0d want %0d", got.lamp_one, want.lamp_one));
      if (got.lamp_two !== want.lamp_two)
        report($sformatf("lamp_two got %0d want %0d", got.lamp_two, want.lamp_two));
      if (got.seg_one_units !== want.seg_one_units)
        report($sformatf("seg_one_units got %h want %h", got.seg_one_units, want.seg_one_units));
      if (got.seg_one_tens !== want.seg_one_tens)
        report($sformatf("seg_one_tens got %h want %h", got.seg_one_tens, want.seg_one_tens));
      if (got.seg_two_units !== want.seg_two_units)
        report($sformatf("seg_two_units got %h want %h", got.seg_two_units, want.seg_two_units));
      if (got.seg_two_tens !== want.seg_two_tens)
        report($sformatf("seg_two_tens got %h want %h", got.seg_two_tens, want.seg_two_tens));
    endtask

    task close_out();
      if (due_lamps.size() != 0)
        report($sformatf("%0d results never arrived", due_lamps.size()));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  twtl_in_if  pass_ch ();
  twtl_out_if lamps_ch ();

  lamp_ledger ledger = new();

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int holds_asked     = 0;
  int holds_done      = 0;
  int quiet_cycles    = 0;

  two_way_traffic_light_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .pass_in   (pass_ch),
    .lamps_out (lamps_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold whenever one is asked for
  initial begin
    lamps_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_asked) begin
        lamps_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        lamps_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && lamps_ch.valid === 1'b1 && lamps_ch.ready === 1'b1)
      ledger.check_lamps({lamps_ch.lamp_one, lamps_ch.lamp_two,
                          lamps_ch.seg_one_units, lamps_ch.seg_one_tens,
                          lamps_ch.seg_two_units, lamps_ch.seg_two_tens});
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((pass_ch.valid && pass_ch.ready) || (lamps_ch.valid && lamps_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(bit a, bit o, bit f, bit p1, bit p2, bit t);
    in_item_t p;
    p.press_auto     = a;
    p.press_off      = o;
    p.press_flash    = f;
    p.press_prio_one = p1;
    p.press_prio_two = p2;
    p.second_tick    = t;
    return p;
  endfunction

  // Mostly plain passes; now and then a button, leaning towards auto
  function automatic in_item_t random_pass(int noise_pct, int tick_pct);
    in_item_t p;
    p = '0;
    if ($urandom_range(99) < noise_pct) begin
      if ($urandom_range(1) == 1)
        p.press_auto = 1'b1;
      else
        {p.press_auto, p.press_off, p.press_flash, p.press_prio_one, p.press_prio_two} =
          5'($urandom_range(31));
    end
    p.second_tick = ($urandom_range(99) < tick_pct);
    return p;
  endfunction

  task automatic send_pass(in_item_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      pass_ch.valid <= 1'b0;
    end
    @(negedge clk);
    pass_ch.valid          <= 1'b1;
    pass_ch.press_auto     <= p.press_auto;
    pass_ch.press_off      <= p.press_off;
    pass_ch.press_flash    <= p.press_flash;
    pass_ch.press_prio_one <= p.press_prio_one;
    pass_ch.press_prio_two <= p.press_prio_two;
    pass_ch.second_tick    <= p.second_tick;
    do @(posedge clk); while (pass_ch.ready !== 1'b1);
    ledger.note_pass(p);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    @(negedge clk);
    pass_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    ledger.set_timing(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_times(int g1, int y1, int g2, int y2);
    settle();
    write_reg(CFG_GREEN_ONE,  7'(g1));
    write_reg(CFG_YELLOW_ONE, 7'(y1));
    write_reg(CFG_GREEN_TWO,  7'(g2));
    write_reg(CFG_YELLOW_TWO, 7'(y2));
  endtask

  task automatic run_random(int idle, int stall, int count, int noise_pct, int tick_pct);
    sender_idle_pct = idle;
    stall_pct       = stall;
    send_pass(make_item(1, 0, 0, 0, 0, 0));
    repeat (count) send_pass(random_pass(noise_pct, tick_pct));
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_GREEN_ONE;
    cfg_data               = '0;
    pass_ch.valid          = 1'b0;
    pass_ch.press_auto     = 1'b0;
    pass_ch.press_off      = 1'b0;
    pass_ch.press_flash    = 1'b0;
    pass_ch.press_prio_one = 1'b0;
    pass_ch.press_prio_two = 1'b0;
    pass_ch.second_tick    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed passes at the default times
    send_pass(make_item(0, 0, 0, 0, 0, 0));
    send_pass(make_item(0, 0, 0, 0, 0, 1));  // tick ignored while off
    send_pass(make_item(1, 0, 0, 0, 0, 0));  // enter auto, countdowns load
    repeat (3) send_pass(make_item(0, 0, 0, 0, 0, 1));
    send_pass(make_item(1, 1, 0, 0, 0, 1));  // off beats auto
    send_pass(make_item(0, 0, 1, 0, 0, 0));  // flash folds phase back to zero
    send_pass(make_item(0, 0, 0, 0, 0, 1));
    send_pass(make_item(0, 0, 0, 0, 0, 1));
    send_pass(make_item(0, 0, 1, 0, 0, 1));
    send_pass(make_item(0, 0, 0, 1, 0, 1));  // priority one holds, tick ignored
    send_pass(make_item(0, 0, 0, 0, 1, 0));
    send_pass(make_item(0, 0, 0, 1, 1, 1));  // priority two wins
    send_pass(make_item(1, 1, 1, 1, 1, 1));
    send_pass(make_item(1, 0, 1, 0, 0, 0));  // flash beats auto
    send_pass(make_item(1, 0, 0, 0, 0, 1));
    repeat (10) send_pass(make_item(0, 0, 0, 0, 0, 1));  // cross the first boundary

    load_times(10, 3, 10, 3);
    run_random(0, 0, 100, 10, 60);
    load_times(1, 1, 1, 1);
    run_random(55, 0, 150, 10, 50);
    load_times(79, 20, 79, 20);
    run_random(0, 55, 150, 2, 90);
    load_times($urandom_range(1, 79), $urandom_range(1, 20),
               $urandom_range(1, 79), $urandom_range(1, 20));
    run_random(16, 16, 150, 10, 60);
    // all times zero: phase stays at zero, no lamp range matches, lamps stay dark
    load_times(0, 0, 0, 0);
    run_random(0, 0, 60, 15, 50);
    // times above the phase range: phase saturates
    load_times(127, 31, 127, 31);
    run_random(0, 0, 350, 1, 95);

    // Hold the receiver off while passes keep coming, so the input stalls
    load_times($urandom_range(1, 20), $urandom_range(1, 5),
               $urandom_range(1, 20), $urandom_range(1, 5));
    holds_asked++;
    run_random(0, 0, 60, 10, 60);
    settle();
    run_random(16, 16, 60, 10, 60);

    settle();
    repeat (10) @(posedge clk);
    ledger.close_out();
    if (ledger.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/twtl_pkg.sv
hdl/twtl_in_if.sv
hdl/twtl_out_if.sv
hdl/twtl_core.sv
hdl/two_way_traffic_light_controller.sv
bench/tb_two_way_traffic_light_controller.sv
